// File: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the raster rect address stepper
// Command codes, register indexes, corner codes and the configuration
// bundle passed from the register file to the datapath stages.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Default sizes
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned ADDR_BITS_DEF  = 32;

  // Fixed field widths
  localparam int unsigned LIM_W    = 16;  // holds a last column/row at any coordinate width
  localparam int unsigned ORIGIN_W = 32;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned CFG_IW   = 3;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned CORNER_W = 2;

  // Step commands
  typedef enum logic [FUNC_W-1:0] {
    FUNC_FWD    = 3'd0,
    FUNC_BWD    = 3'd1,
    FUNC_UP     = 3'd2,
    FUNC_DOWN   = 3'd3,
    FUNC_SET    = 3'd4,
    FUNC_CORNER = 3'd5
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_ORIGIN_A = 3'd0,
    REG_PITCH_A  = 3'd1,
    REG_ORIGIN_B = 3'd2,
    REG_PITCH_B  = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } reg_e;

  // Corner codes for jump to corner: top-left, top-right, bottom-left, bottom-right
  localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_BL = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_BR = 2'd3;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_a;
    logic [PITCH_W-1:0]  pitch_a;
    logic [ORIGIN_W-1:0] origin_b;
    logic [PITCH_W-1:0]  pitch_b;
    logic [LIM_W-1:0]    xlim;    // last column, saturated
    logic [LIM_W-1:0]    ylim;    // last row, saturated
    logic                recalc;  // row offset products being rebuilt
  } cfg_t;

endpackage

// File: rtl/rrs_cfg.sv
// ----------------------------------------------------------------------------
// rrs_cfg: configuration registers
// Holds origins, pitches and region size, derives the last column and row,
// and rebuilds the last-row offset products in the cycle after any write.
// ----------------------------------------------------------------------------
module rrs_cfg #(
  parameter int unsigned COORD_BITS = rrs_pkg::COORD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = rrs_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rrs_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [rrs_pkg::CFG_DW-1:0]  cfg_data_i,
  output rrs_pkg::cfg_t               cfg_o,
  output logic [ADDR_BITS-1:0]        yp_a_o,
  output logic [ADDR_BITS-1:0]        yp_b_o
);

  localparam int unsigned LW  = rrs_pkg::LIM_W;
  localparam int unsigned SW  = rrs_pkg::SIZE_W;
  localparam int unsigned PW  = rrs_pkg::PITCH_W;
  localparam int unsigned OW  = rrs_pkg::ORIGIN_W;
  localparam int unsigned MW  = LW + PW;
  localparam int unsigned AW  = ADDR_BITS;
  localparam logic [LW-1:0] COORD_MAX = LW'((32'd1 << COORD_BITS) - 32'd1);

  logic [OW-1:0] origin_a_q, origin_b_q;
  logic [PW-1:0] pitch_a_q, pitch_b_q;
  logic [SW-1:0] width_q, height_q;
  logic          recalc_q;
  logic [AW-1:0] yp_a_q, yp_b_q;
  logic [LW-1:0] xlim, ylim;
  logic [MW-1:0] yp_a_full, yp_b_full;

  // Last index of a size: zero counts as one, clipped to the coordinate range
  function automatic logic [LW-1:0] last_index(input logic [SW-1:0] size);
    logic [SW-1:0] v;
    v = (size == '0) ? '0 : size - 1'b1;
    return (LW'(v) > COORD_MAX) ? COORD_MAX : LW'(v);
  endfunction

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_a_q <= '0;
      pitch_a_q  <= PW'(1);
      origin_b_q <= '0;
      pitch_b_q  <= PW'(1);
      width_q    <= SW'(1);
      height_q   <= SW'(1);
    end else if (cfg_we_i) begin
      case (rrs_pkg::reg_e'(cfg_idx_i))
        rrs_pkg::REG_ORIGIN_A: origin_a_q <= cfg_data_i[OW-1:0];
        rrs_pkg::REG_PITCH_A:  pitch_a_q  <= cfg_data_i[PW-1:0];
        rrs_pkg::REG_ORIGIN_B: origin_b_q <= cfg_data_i[OW-1:0];
        rrs_pkg::REG_PITCH_B:  pitch_b_q  <= cfg_data_i[PW-1:0];
        rrs_pkg::REG_WIDTH:    width_q    <= cfg_data_i[SW-1:0];
        rrs_pkg::REG_HEIGHT:   height_q   <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  assign xlim = last_index(width_q);
  assign ylim = last_index(height_q);

  // Last-row offsets, rebuilt in the cycle after a write
  assign yp_a_full = MW'(ylim) * MW'(pitch_a_q);
  assign yp_b_full = MW'(ylim) * MW'(pitch_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recalc_q <= 1'b0;
      yp_a_q   <= '0;
      yp_b_q   <= '0;
    end else begin
      recalc_q <= cfg_we_i;
      if (recalc_q) begin
        yp_a_q <= AW'(yp_a_full);
        yp_b_q <= AW'(yp_b_full);
      end
    end
  end

  always_comb begin
    cfg_o.origin_a = origin_a_q;
    cfg_o.pitch_a  = pitch_a_q;
    cfg_o.origin_b = origin_b_q;
    cfg_o.pitch_b  = pitch_b_q;
    cfg_o.xlim     = xlim;
    cfg_o.ylim     = ylim;
    cfg_o.recalc   = recalc_q;
  end

  assign yp_a_o = yp_a_q;
  assign yp_b_o = yp_b_q;

endmodule

// File: rtl/rrs_prep.sv
// ----------------------------------------------------------------------------
// rrs_prep: input register and target precompute
// Registers each command, then works out the clamped or corner target
// position and its row offsets in both surfaces for the step stage.
// ----------------------------------------------------------------------------
module rrs_prep #(
  parameter int unsigned COORD_BITS = rrs_pkg::COORD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = rrs_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrs_pkg::cfg_t                 cfg_i,
  // command side
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [rrs_pkg::FUNC_W-1:0]    func_i,
  input  logic [COORD_BITS-1:0]         pos_x_i,
  input  logic [COORD_BITS-1:0]         pos_y_i,
  input  logic [rrs_pkg::CORNER_W-1:0]  corner_i,
  // toward the step stage
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rrs_pkg::func_e                out_func_o,
  output logic [COORD_BITS-1:0]         out_col_o,
  output logic [COORD_BITS-1:0]         out_row_o,
  output logic [ADDR_BITS-1:0]          out_prod_a_o,
  output logic [ADDR_BITS-1:0]          out_prod_b_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned PRW = COORD_BITS + rrs_pkg::PITCH_W;

  logic                         v1_q, v2_q;
  logic                         r1, r2;
  rrs_pkg::func_e               func1_q, func2_q;
  logic [CW-1:0]                px1_q, py1_q;
  logic [rrs_pkg::CORNER_W-1:0] corner1_q;
  logic [CW-1:0]                xlim, ylim, tcol, trow;
  logic [PRW-1:0]               prod_a, prod_b;
  logic [CW-1:0]                col2_q, row2_q;
  logic [AW-1:0]                prod_a2_q, prod_b2_q;
  logic                         right, bottom;

  // Stage readiness, filling bubbles
  assign r2        = !v2_q || out_ready_i;
  assign r1        = !v1_q || r2;
  assign s_ready_o = r1 && !cfg_i.recalc;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (r1) begin
      v1_q <= s_valid_i && s_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      func1_q   <= rrs_pkg::func_e'(func_i);
      px1_q     <= pos_x_i;
      py1_q     <= pos_y_i;
      corner1_q <= corner_i;
    end
  end

  // Target position: corner pick or clamped set position
  assign xlim   = CW'(cfg_i.xlim);
  assign ylim   = CW'(cfg_i.ylim);
  assign right  = (corner1_q == rrs_pkg::CORNER_TR) ||
                  (corner1_q == rrs_pkg::CORNER_BR);
  assign bottom = (corner1_q == rrs_pkg::CORNER_BL) ||
                  (corner1_q == rrs_pkg::CORNER_BR);

  always_comb begin
    if (func1_q == rrs_pkg::FUNC_CORNER) begin
      tcol = right  ? xlim : '0;
      trow = bottom ? ylim : '0;
    end else begin
      tcol = (px1_q > xlim) ? xlim : px1_q;
      trow = (py1_q > ylim) ? ylim : py1_q;
    end
  end

  // Row offsets of the target in each surface
  assign prod_a = PRW'(trow) * PRW'(cfg_i.pitch_a);
  assign prod_b = PRW'(trow) * PRW'(cfg_i.pitch_b);

  // Precompute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (r2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      func2_q   <= func1_q;
      col2_q    <= tcol;
      row2_q    <= trow;
      prod_a2_q <= AW'(prod_a);
      prod_b2_q <= AW'(prod_b);
    end
  end

  assign out_valid_o  = v2_q;
  assign out_func_o   = func2_q;
  assign out_col_o    = col2_q;
  assign out_row_o    = row2_q;
  assign out_prod_a_o = prod_a2_q;
  assign out_prod_b_o = prod_b2_q;

endmodule

// File: rtl/rrs_exec.sv
// ----------------------------------------------------------------------------
// rrs_exec: position and address step stage
// Applies one command per cycle to the position, both addresses and the end
// flag, unless the result side stalls. The state registers double as the
// result register.
module rrs_exec #(
  parameter int unsigned COORD_BITS = rrs_pkg::COORD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = rrs_pkg::ADDR_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rrs_pkg::cfg_t           cfg_i,
  input  logic [ADDR_BITS-1:0]    yp_a_i,
  input  logic [ADDR_BITS-1:0]    yp_b_i,
  // from the precompute stage
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rrs_pkg::func_e          func_i,
  input  logic [COORD_BITS-1:0]   col_i,
  input  logic [COORD_BITS-1:0]   row_i,
  input  logic [ADDR_BITS-1:0]    prod_a_i,
  input  logic [ADDR_BITS-1:0]    prod_b_i,
  // result side
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  output logic [COORD_BITS-1:0]   cur_col_o,
  output logic [COORD_BITS-1:0]   cur_row_o,
  output logic [ADDR_BITS-1:0]    addr_a_o,
  output logic [ADDR_BITS-1:0]    addr_b_o,
  output logic                    at_end_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned PRW = COORD_BITS + rrs_pkg::PITCH_W;

  logic           valid_q, fire;
  logic [CW-1:0]  col_q, row_q, col_d, row_d;
  logic [AW-1:0]  addr_a_q, addr_b_q, addr_a_d, addr_b_d;
  logic [AW-1:0]  rp_a_q, rp_b_q, rp_a_d, rp_b_d;   // row_q times pitch
  logic           end_q, end_d;
  logic [CW-1:0]  xlim, ylim;
  logic [AW-1:0]  pa, pb, col_e, xlim_e, org_a, org_b, tcol_e;
  logic [PRW-1:0] rp_a_full, rp_b_full;

  assign in_ready_o = !valid_q || m_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign xlim   = CW'(cfg_i.xlim);
  assign ylim   = CW'(cfg_i.ylim);
  assign pa     = AW'(cfg_i.pitch_a);
  assign pb     = AW'(cfg_i.pitch_b);
  assign org_a  = AW'(cfg_i.origin_a);
  assign org_b  = AW'(cfg_i.origin_b);
  assign col_e  = AW'(col_q);
  assign xlim_e = AW'(xlim);
  assign tcol_e = AW'(col_i);

  // Row offset rebuild after a pitch or size change
  assign rp_a_full = PRW'(row_q) * PRW'(cfg_i.pitch_a);
  assign rp_b_full = PRW'(row_q) * PRW'(cfg_i.pitch_b);

  // Next state for one command
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    addr_a_d = addr_a_q;
    addr_b_d = addr_b_q;
    rp_a_d   = rp_a_q;
    rp_b_d   = rp_b_q;
    end_d    = end_q;
    case (func_i)
      rrs_pkg::FUNC_FWD: begin
        end_d = 1'b0;
        if (col_q >= xlim) begin
          col_d = '0;
          if (row_q >= ylim) begin
            // wrap to the region start
            row_d    = '0;
            addr_a_d = addr_a_q - col_e - rp_a_q;
            addr_b_d = addr_b_q - col_e - rp_b_q;
            rp_a_d   = '0;
            rp_b_d   = '0;
            end_d    = 1'b1;
          end else begin
            row_d    = row_q + 1'b1;
            addr_a_d = addr_a_q - col_e + pa;
            addr_b_d = addr_b_q - col_e + pb;
            rp_a_d   = rp_a_q + pa;
            rp_b_d   = rp_b_q + pb;
          end
        end else begin
          col_d    = col_q + 1'b1;
          addr_a_d = addr_a_q + 1'b1;
          addr_b_d = addr_b_q + 1'b1;
        end
      end
      rrs_pkg::FUNC_BWD: begin
        end_d = 1'b0;
        if (col_q == '0) begin
          col_d = xlim;
          if (row_q == '0) begin
            // wrap to the region end
            row_d    = ylim;
            addr_a_d = addr_a_q + xlim_e + yp_a_i;
            addr_b_d = addr_b_q + xlim_e + yp_b_i;
            rp_a_d   = yp_a_i;
            rp_b_d   = yp_b_i;
            end_d    = 1'b1;
          end else begin
            row_d    = row_q - 1'b1;
            addr_a_d = addr_a_q + xlim_e - pa;
            addr_b_d = addr_b_q + xlim_e - pb;
            rp_a_d   = rp_a_q - pa;
            rp_b_d   = rp_b_q - pb;
          end
        end else begin
          col_d    = col_q - 1'b1;
          addr_a_d = addr_a_q - 1'b1;
          addr_b_d = addr_b_q - 1'b1;
        end
      end
      rrs_pkg::FUNC_UP: begin
        if (row_q == '0) begin
          end_d = 1'b1;
        end else begin
          row_d    = row_q - 1'b1;
          addr_a_d = addr_a_q - pa;
          addr_b_d = addr_b_q - pb;
          rp_a_d   = rp_a_q - pa;
          rp_b_d   = rp_b_q - pb;
        end
      end
      rrs_pkg::FUNC_DOWN: begin
        if (row_q >= ylim) begin
          end_d = 1'b1;
        end else begin
          row_d    = row_q + 1'b1;
          addr_a_d = addr_a_q + pa;
          addr_b_d = addr_b_q + pb;
          rp_a_d   = rp_a_q + pa;
          rp_b_d   = rp_b_q + pb;
        end
      end
      rrs_pkg::FUNC_SET, rrs_pkg::FUNC_CORNER: begin
        col_d    = col_i;
        row_d    = row_i;
        addr_a_d = org_a + prod_a_i + tcol_e;
        addr_b_d = org_b + prod_b_i + tcol_e;
        rp_a_d   = prod_a_i;
        rp_b_d   = prod_b_i;
        end_d    = 1'b0;
      end
      default: ;
    endcase
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      addr_a_q <= '0;
      addr_b_q <= '0;
      rp_a_q   <= '0;
      rp_b_q   <= '0;
      end_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (fire) begin
        col_q    <= col_d;
        row_q    <= row_d;
        addr_a_q <= addr_a_d;
        addr_b_q <= addr_b_d;
        rp_a_q   <= rp_a_d;
        rp_b_q   <= rp_b_d;
        end_q    <= end_d;
      end else if (cfg_i.recalc) begin
        rp_a_q <= AW'(rp_a_full);
        rp_b_q <= AW'(rp_b_full);
      end
    end
  end

  assign m_valid_o = valid_q;
  assign cur_col_o = col_q;
  assign cur_row_o = row_q;
  assign addr_a_o  = addr_a_q;
  assign addr_b_o  = addr_b_q;
  assign at_end_o  = end_q;

endmodule

// File: rtl/raster_rect_address_stepper_unit.sv
// ----------------------------------------------------------------------------
// raster_rect_address_stepper_unit: two-surface raster address stepper
// Walks a shared column/row position over a clip rectangle and keeps the
// matching pixel addresses of two surfaces, one result per command.
// ----------------------------------------------------------------------------
// The unit takes one command per clock, unless the input is held off or the
// result side stalls, and gives one result per command. Each command passes
// the input register, which loads on the transfer edge, then the target
// precompute register, then the step stage, which is also the result
// register. Commands stream back to back: the step stage updates the
// position and both addresses with adds only, because the row offsets of the
// current row and of the last row are kept in registers; set position and
// jump to corner get their multiply done one stage earlier. After any
// configuration write the input is held off while those row offsets are
// rebuilt from the new pitch and height. Addresses wrap modulo 2^ADDR_BITS;
// the end flag travels on m_axis_tlast.
module raster_rect_address_stepper_unit #(
  parameter int unsigned COORD_BITS = rrs_pkg::COORD_BITS_DEF,
  parameter int unsigned ADDR_BITS  = rrs_pkg::ADDR_BITS_DEF,
  localparam int unsigned IN_DW  = ((2 * COORD_BITS + rrs_pkg::CORNER_W + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((2 * COORD_BITS + 2 * ADDR_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [rrs_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [rrs_pkg::CFG_DW-1:0]   cfg_data_i,
  // command stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [IN_DW-1:0]             s_axis_tdata,   // pos_x, pos_y, corner
  input  logic [rrs_pkg::FUNC_W-1:0]   s_axis_tuser,   // func
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OUT_DW-1:0]            m_axis_tdata,   // cur_col, cur_row, address_a, address_b
  output logic                         m_axis_tlast    // at_end
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned AW = ADDR_BITS;

  rrs_pkg::cfg_t  cfg;
  logic [AW-1:0]  yp_a, yp_b;
  logic           p_valid, p_ready;
  rrs_pkg::func_e p_func;
  logic [CW-1:0]  p_col, p_row;
  logic [AW-1:0]  p_prod_a, p_prod_b;
  logic [CW-1:0]  cur_col, cur_row;
  logic [AW-1:0]  addr_a, addr_b;

  // Configuration registers
  rrs_cfg #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .yp_a_o     (yp_a),
    .yp_b_o     (yp_b)
  );

  // Input register and target precompute
  rrs_prep #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .func_i       (s_axis_tuser),
    .pos_x_i      (s_axis_tdata[CW-1:0]),
    .pos_y_i      (s_axis_tdata[2*CW-1:CW]),
    .corner_i     (s_axis_tdata[2*CW+rrs_pkg::CORNER_W-1:2*CW]),
    .out_valid_o  (p_valid),
    .out_ready_i  (p_ready),
    .out_func_o   (p_func),
    .out_col_o    (p_col),
    .out_row_o    (p_row),
    .out_prod_a_o (p_prod_a),
    .out_prod_b_o (p_prod_b)
  );

  // Step stage and result register
  rrs_exec #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .yp_a_i     (yp_a),
    .yp_b_i     (yp_b),
    .in_valid_i (p_valid),
    .in_ready_o (p_ready),
    .func_i     (p_func),
    .col_i      (p_col),
    .row_i      (p_row),
    .prod_a_i   (p_prod_a),
    .prod_b_i   (p_prod_b),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .cur_col_o  (cur_col),
    .cur_row_o  (cur_row),
    .addr_a_o   (addr_a),
    .addr_b_o   (addr_b),
    .at_end_o   (m_axis_tlast)
  );

  // Result packing, zero padded to whole bytes
  assign m_axis_tdata = OUT_DW'({addr_b, addr_a, cur_row, cur_col});

endmodule

// File: sim/raster_rect_address_stepper_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_rect_address_stepper_unit_test: self-checking bench for the stepper
// Streams step commands through the unit under random valid and ready gaps.
// A local copy of the position, both addresses and the end flag predicts
// each result, and every result is checked field by field. The clip region,
// origins and pitches are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module raster_rect_address_stepper_unit_test;

  // Spare command codes: the unit must leave its state alone
  localparam logic [rrs_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [rrs_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  localparam int unsigned RAND_PHASES   = 9;
  localparam int unsigned CMDS_PER_PHASE = 100;

  typedef struct {
    logic [rrs_pkg::FUNC_W-1:0]   func;
    logic [11:0]                  px;
    logic [11:0]                  py;
    logic [rrs_pkg::CORNER_W-1:0] corner;
  } step_cmd_t;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic        at_end;
  } step_pos_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [rrs_pkg::CFG_IW-1:0] cfg_idx_i = '0;
  logic [rrs_pkg::CFG_DW-1:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // pos_x[11:0], pos_y[23:12], corner[25:24]
  logic [rrs_pkg::FUNC_W-1:0] s_axis_tuser = '0;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;   // cur_col[11:0], cur_row[23:12], address_a[55:24], address_b[87:56]
  logic        m_axis_tlast;   // at_end

  raster_rect_address_stepper_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Commands waiting to be driven and positions waiting to come out
  step_cmd_t cmd_items[$];
  step_pos_t pos_expected[$];

  int unsigned driven_cnt = 0;
  int unsigned cmd_xfers = 0;
  int unsigned res_xfers = 0;
  int unsigned cfg_writes = 0;
  int unsigned err_cnt = 0;
  bit          calm = 1'b0;
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;

  // Predicted configuration (reset values)
  logic [31:0] org_a = '0;
  logic [15:0] pit_a = 16'd1;
  logic [31:0] org_b = '0;
  logic [15:0] pit_b = 16'd1;
  logic [12:0] reg_w = 13'd1;
  logic [12:0] reg_h = 13'd1;

  // Predicted walker state
  logic [11:0] pos_col = '0;
  logic [11:0] pos_row = '0;
  logic [31:0] adr_a = '0;
  logic [31:0] adr_b = '0;
  logic        end_q = 1'b0;

  // Last column/row index: zero size acts as one, large sizes saturate
  function automatic logic [11:0] last_of(input logic [12:0] size);
    if (size == '0) return '0;
    if (size > 13'd4096) return 12'hFFF;
    return 12'(size - 13'd1);
  endfunction

  // Apply one command to the predicted state and queue the result
  task automatic walk_step(input step_cmd_t c);
    logic [11:0] xl, yl, nx, ny;
    bit          placed;
    step_pos_t   r;
    xl = last_of(reg_w);
    yl = last_of(reg_h);
    placed = 1'b0;
    nx = '0;
    ny = '0;
    case (c.func)
      rrs_pkg::FUNC_FWD: begin
        end_q = 1'b0;
        if (pos_col >= xl) begin
          adr_a -= 32'(pos_col);
          adr_b -= 32'(pos_col);
          pos_col = '0;
          if (pos_row >= yl) begin
            adr_a -= 32'(pos_row) * 32'(pit_a);
            adr_b -= 32'(pos_row) * 32'(pit_b);
            pos_row = '0;
            end_q = 1'b1;
          end else begin
            pos_row++;
            adr_a += 32'(pit_a);
            adr_b += 32'(pit_b);
          end
        end else begin
          pos_col++;
          adr_a++;
          adr_b++;
        end
      end
      rrs_pkg::FUNC_BWD: begin
        end_q = 1'b0;
        if (pos_col == '0) begin
          pos_col = xl;
          adr_a += 32'(xl);
          adr_b += 32'(xl);
          if (pos_row == '0) begin
            pos_row = yl;
            adr_a += 32'(yl) * 32'(pit_a);
            adr_b += 32'(yl) * 32'(pit_b);
            end_q = 1'b1;
          end else begin
            pos_row--;
            adr_a -= 32'(pit_a);
            adr_b -= 32'(pit_b);
          end
        end else begin
          pos_col--;
          adr_a--;
          adr_b--;
        end
      end
      rrs_pkg::FUNC_UP: begin
        if (pos_row == '0) begin
          end_q = 1'b1;
        end else begin
          pos_row--;
          adr_a -= 32'(pit_a);
          adr_b -= 32'(pit_b);
        end
      end
      rrs_pkg::FUNC_DOWN: begin
        if (pos_row >= yl) begin
          end_q = 1'b1;
        end else begin
          pos_row++;
          adr_a += 32'(pit_a);
          adr_b += 32'(pit_b);
        end
      end
      rrs_pkg::FUNC_SET: begin
        placed = 1'b1;
        nx = (c.px > xl) ? xl : c.px;
        ny = (c.py > yl) ? yl : c.py;
      end
      rrs_pkg::FUNC_CORNER: begin
        placed = 1'b1;
        nx = (c.corner == rrs_pkg::CORNER_TR || c.corner == rrs_pkg::CORNER_BR) ? xl : '0;
        ny = (c.corner == rrs_pkg::CORNER_BL || c.corner == rrs_pkg::CORNER_BR) ? yl : '0;
      end
      default: ;  // spare codes leave everything as is
    endcase
    // Absolute placement recomputes both addresses from the origins
    if (placed) begin
      pos_col = nx;
      pos_row = ny;
      adr_a = org_a + 32'(ny) * 32'(pit_a) + 32'(nx);
      adr_b = org_b + 32'(ny) * 32'(pit_b) + 32'(nx);
      end_q = 1'b0;
    end
    r.col = pos_col;
    r.row = pos_row;
    r.addr_a = adr_a;
    r.addr_b = adr_b;
    r.at_end = end_q;
    pos_expected.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Input driver: holds an item until its transfer, then idles or moves on
  always @(negedge clk_i) begin
    step_cmd_t c;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && driven_cnt != cmd_xfers) begin
      // still waiting for the transfer
    end else if (idle_left > 0) begin
      idle_left--;
      s_axis_tvalid <= 1'b0;
    end else if (cmd_items.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      idle_left = $urandom_range(1, 6) - 1;
      s_axis_tvalid <= 1'b0;
    end else begin
      c = cmd_items.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {6'b0, c.corner, c.py, c.px};
      s_axis_tuser  <= c.func;
      driven_cnt++;
    end
  end

  // Result ready with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    step_cmd_t c;
    step_pos_t e;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.func   = s_axis_tuser;
      c.px     = s_axis_tdata[11:0];
      c.py     = s_axis_tdata[23:12];
      c.corner = s_axis_tdata[25:24];
      walk_step(c);
      cmd_xfers++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_xfers++;
      if (pos_expected.size() == 0) begin
        $error("result with no command pending: tdata %0h tlast %0b",
               m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        e = pos_expected.pop_front();
        check_field("cur_col", 32'(e.col), 32'(m_axis_tdata[11:0]));
        check_field("cur_row", 32'(e.row), 32'(m_axis_tdata[23:12]));
        check_field("address_a", e.addr_a, m_axis_tdata[55:24]);
        check_field("address_b", e.addr_b, m_axis_tdata[87:56]);
        check_field("at_end", 32'(e.at_end), 32'(m_axis_tlast));
      end
    end
  end

  task automatic queue_cmd(input logic [rrs_pkg::FUNC_W-1:0] f, input logic [11:0] x,
                           input logic [11:0] y, input logic [rrs_pkg::CORNER_W-1:0] cr);
    step_cmd_t c;
    c.func = f;
    c.px = x;
    c.py = y;
    c.corner = cr;
    cmd_items.push_back(c);
  endtask

  // Block until every queued command went through and every result came back
  task automatic wait_drained();
    while (cmd_items.size() != 0 || driven_cnt != cmd_xfers || pos_expected.size() != 0)
      @(posedge clk_i);
  endtask

  // Register write, only once the unit is drained
  task automatic write_reg(input rrs_pkg::reg_e idx, input logic [31:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      rrs_pkg::REG_ORIGIN_A: org_a = val;
      rrs_pkg::REG_PITCH_A:  pit_a = val[15:0];
      rrs_pkg::REG_ORIGIN_B: org_b = val;
      rrs_pkg::REG_PITCH_B:  pit_b = val[15:0];
      rrs_pkg::REG_WIDTH:    reg_w = val[12:0];
      rrs_pkg::REG_HEIGHT:   reg_h = val[12:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_pitch();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Mostly small regions so the walk wraps often; sometimes full or oversized
  function automatic logic [12:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom_range(4097, 8191));
      3: return 13'($urandom_range(10, 4095));
      default: return 13'($urandom_range(1, 9));
    endcase
  endfunction

  task automatic queue_random_cmd();
    int unsigned sel;
    logic [11:0] x, y;
    sel = $urandom_range(0, 99);
    // set position: half inside the region, half anywhere in the field
    if ($urandom_range(0, 1) == 0) begin
      x = 12'($urandom_range(0, last_of(reg_w)));
      y = 12'($urandom_range(0, last_of(reg_h)));
    end else begin
      x = 12'($urandom);
      y = 12'($urandom);
    end
    if (sel < 35)      queue_cmd(rrs_pkg::FUNC_FWD, x, y, 2'($urandom));
    else if (sel < 55) queue_cmd(rrs_pkg::FUNC_BWD, x, y, 2'($urandom));
    else if (sel < 67) queue_cmd(rrs_pkg::FUNC_UP, x, y, 2'($urandom));
    else if (sel < 79) queue_cmd(rrs_pkg::FUNC_DOWN, x, y, 2'($urandom));
    else if (sel < 89) queue_cmd(rrs_pkg::FUNC_SET, x, y, 2'($urandom));
    else if (sel < 97) queue_cmd(rrs_pkg::FUNC_CORNER, x, y, 2'($urandom));
    else if (sel < 99) queue_cmd(FUNC_SPARE_LO, x, y, 2'($urandom));
    else               queue_cmd(FUNC_SPARE_HI, x, y, 2'($urandom));
  endtask

  // Stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: one-pixel region, wrap at once, clamped placement, spare code
    queue_cmd(rrs_pkg::FUNC_FWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_UP, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_SET, 12'hFFF, 12'hFFF, rrs_pkg::CORNER_TL);
    queue_cmd(FUNC_SPARE_HI, 12'hFFF, 12'hFFF, rrs_pkg::CORNER_BR);

    // 3x2 region, A wraps past 2^32 with the widest pitch, B has zero pitch
    write_reg(rrs_pkg::REG_ORIGIN_A, 32'hFFFF_FFF0);
    write_reg(rrs_pkg::REG_PITCH_A, 32'h0000_FFFF);
    write_reg(rrs_pkg::REG_ORIGIN_B, 32'h0000_0000);
    write_reg(rrs_pkg::REG_PITCH_B, 32'h0000_0000);
    write_reg(rrs_pkg::REG_WIDTH, 32'd3);
    write_reg(rrs_pkg::REG_HEIGHT, 32'd2);
    queue_cmd(rrs_pkg::FUNC_CORNER, 12'd0, 12'd0, rrs_pkg::CORNER_BR);
    queue_cmd(rrs_pkg::FUNC_FWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);   // wraps the region
    queue_cmd(rrs_pkg::FUNC_BWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);   // wraps backward
    queue_cmd(rrs_pkg::FUNC_BWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_DOWN, 12'd0, 12'd0, rrs_pkg::CORNER_TL);  // stuck at bottom
    queue_cmd(rrs_pkg::FUNC_UP, 12'd0, 12'd0, rrs_pkg::CORNER_TL);    // flag stays set
    queue_cmd(rrs_pkg::FUNC_UP, 12'd0, 12'd0, rrs_pkg::CORNER_TL);    // stuck at top
    queue_cmd(rrs_pkg::FUNC_CORNER, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_CORNER, 12'd0, 12'd0, rrs_pkg::CORNER_TR);
    queue_cmd(rrs_pkg::FUNC_CORNER, 12'd0, 12'd0, rrs_pkg::CORNER_BL);
    queue_cmd(rrs_pkg::FUNC_FWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_SET, 12'hFFF, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(FUNC_SPARE_LO, 12'h555, 12'hAAA, rrs_pkg::CORNER_TR);
    queue_cmd(rrs_pkg::FUNC_SET, 12'd1, 12'd1, rrs_pkg::CORNER_TL);

    // Oversized width saturates, zero height acts as one row
    write_reg(rrs_pkg::REG_WIDTH, 32'd8191);
    write_reg(rrs_pkg::REG_HEIGHT, 32'd0);
    queue_cmd(rrs_pkg::FUNC_SET, 12'hFFF, 12'hFFF, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_FWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_BWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);

    // Full region, park in the far corner, then shrink around the position
    write_reg(rrs_pkg::REG_WIDTH, 32'd4096);
    write_reg(rrs_pkg::REG_HEIGHT, 32'd4096);
    queue_cmd(rrs_pkg::FUNC_SET, 12'hFFF, 12'hFFF, rrs_pkg::CORNER_TL);
    write_reg(rrs_pkg::REG_WIDTH, 32'd2);
    write_reg(rrs_pkg::REG_HEIGHT, 32'd2);
    queue_cmd(rrs_pkg::FUNC_DOWN, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_FWD, 12'd0, 12'd0, rrs_pkg::CORNER_TL);
    queue_cmd(rrs_pkg::FUNC_SET, 12'hAAA, 12'h555, rrs_pkg::CORNER_TL);

    // Random phases, each with a fresh configuration; the last one runs gap-free
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(rrs_pkg::REG_ORIGIN_A, $urandom);
      write_reg(rrs_pkg::REG_PITCH_A, 32'(pick_pitch()));
      write_reg(rrs_pkg::REG_ORIGIN_B, $urandom);
      write_reg(rrs_pkg::REG_PITCH_B, 32'(pick_pitch()));
      write_reg(rrs_pkg::REG_WIDTH, 32'(pick_size()));
      write_reg(rrs_pkg::REG_HEIGHT, 32'(pick_size()));
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < CMDS_PER_PHASE; i++) queue_random_cmd();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d commands and checked %0d results across %0d register writes.",
             cmd_xfers, res_xfers, cfg_writes);
    $display("Errors seen: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending", pos_expected.size());
    $display("simulation failed");
    $finish;
  end

endmodule
